// ===== hw/rtl/bmf_pkg.sv =====
// Shared widths, request codes and the divider result bundle for the
// modular binomial block. No dependencies.
package bmf_pkg;

   localparam int MOD_W  = 30;
   localparam int PROD_W = 2 * MOD_W;
   localparam int ARG_W  = 13;
   localparam int STEP_W = $clog2(PROD_W);

   typedef enum logic [2:0] {
      REQ_COMB  = 3'd0,
      REQ_PERM  = 3'd1,
      REQ_FACT  = 3'd2,
      REQ_INV   = 3'd3,
      REQ_IFACT = 3'd4
   } req_code_type;

   typedef struct packed {
      logic             done;
      logic [MOD_W-1:0] quot;
      logic [MOD_W-1:0] rem;
   } div_result_type;

endpackage

// ===== hw/rtl/bmf_divider.sv =====
// Shift-subtract divider, one quotient bit per cycle, shared by every
// modular reduction and by the modulus-by-index split. Uses bmf_pkg.
module bmf_divider import bmf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [PROD_W-1:0]   dividend,
   input  logic [MOD_W-1:0]    divisor,
   output div_result_type      result
);

   logic                busy_ff;
   logic [STEP_W-1:0]   cnt_ff;
   logic [PROD_W-1:0]   dvd_ff;
   logic [MOD_W-1:0]    dsr_ff;
   logic [MOD_W-1:0]    rem_ff;
   logic [MOD_W-1:0]    quot_ff;
   logic                done_ff;
   logic [MOD_W:0]      trial;
   logic                fits;

   assign trial = {rem_ff, dvd_ff[PROD_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= STEP_W'(PROD_W - 1);
            dvd_ff  <= dividend;
            dsr_ff  <= divisor;
            rem_ff  <= '0;
            quot_ff <= '0;
         end else if (busy_ff) begin
            dvd_ff  <= {dvd_ff[PROD_W-2:0], 1'b0};
            quot_ff <= {quot_ff[MOD_W-2:0], fits};
            rem_ff  <= fits ? MOD_W'(trial - {1'b0, dsr_ff}) : trial[MOD_W-1:0];
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign result.done = done_ff;
   assign result.quot = quot_ff;
   assign result.rem  = rem_ff;

endmodule

// ===== hw/rtl/bmf_ram.sv =====
// One table of the block: single write port, one registered read port.
// Uses bmf_pkg for the entry width.
module bmf_ram import bmf_pkg::*; #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [MOD_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [MOD_W-1:0]  rd_data
);

   logic [MOD_W-1:0] mem [DEPTH];
   logic [MOD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/binomial_mod_factorial_table_core.sv =====
// Top level of the modular binomial block: sequencer, multiplier stage and
// the three tables. Uses bmf_pkg, bmf_divider and bmf_ram.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_type, req_n_value, req_k_value
//   rsp_      out        rsp_valid/rsp_stall  rsp_result_value, rsp_out_of_range
//   csr_      in         csr_valid/csr_ready  csr_modulus
//
// Every modular reduction runs through one shift-subtract divider, and that
// divider sets the pace. A permutation or a combination needs two divider
// runs once the tables cover n; factorial, inverse and inverse-factorial
// requests are plain table lookups. Each new table entry costs four divider
// runs, and an extension first fetches the last filled entries. A rejected
// or out-of-range request goes straight from the check to the response.
// Reset is synchronous: modulus returns to 1000000007 and the filled length
// to 2; table contents need no clearing since entries 0 and 1 are supplied
// by logic and higher entries are written before they are read.
// One request is in flight at a time; a finished response waits in the
// output register while the next request is accepted.
module binomial_mod_factorial_table_core import bmf_pkg::*; #(
   parameter int TABLE_SIZE = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_type,
   input  logic [ARG_W-1:0]  req_n_value,
   input  logic [ARG_W-1:0]  req_k_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [MOD_W-1:0]  rsp_result_value,
   output logic              rsp_out_of_range,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [MOD_W-1:0]  csr_modulus
);

   localparam int ADDR_W = $clog2(TABLE_SIZE);
   localparam int CNT_W  = ADDR_W + 1;
   localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(1000000007);

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_XRD, S_XLATCH, S_XDIV, S_XDIVW, S_XINVA, S_XINVM,
      S_XIV, S_XFAC, S_XWR, S_QRDK, S_QRDN, S_QMUL1, S_QRD2, S_QMUL2, S_QEND,
      S_DIRECT, S_DIRECTW, S_RED, S_REDW, S_DONE
   } state_type;

   state_type           state_ff;
   state_type           ret_ff;
   logic [MOD_W-1:0]    modulus_ff;
   logic [CNT_W-1:0]    filled_ff;
   logic [CNT_W-1:0]    i_ff;
   logic [2:0]          type_ff;
   logic [ARG_W-1:0]    n_ff;
   logic [ARG_W-1:0]    k_ff;
   logic [ARG_W-1:0]    nk_ff;
   logic [MOD_W-1:0]    q_ff;
   logic [MOD_W-1:0]    r_ff;
   logic [MOD_W-1:0]    iv_ff;
   logic [MOD_W-1:0]    fac_prev_ff;
   logic [MOD_W-1:0]    ifac_prev_ff;
   logic [MOD_W-1:0]    fac_new_ff;
   logic [MOD_W-1:0]    a_ff;
   logic [MOD_W-1:0]    acc_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [MOD_W-1:0]    result_ff;
   logic                flag_ff;
   logic                rsp_valid_ff;
   logic [MOD_W-1:0]    rsp_value_ff;
   logic                rsp_flag_ff;
   logic                rd_low_ff;
   logic                rd_one_ff;

   logic [ADDR_W-1:0]   rd_addr;
   logic [MOD_W-1:0]    fac_q;
   logic [MOD_W-1:0]    inv_q;
   logic [MOD_W-1:0]    ifac_q;
   logic [MOD_W-1:0]    fac_val;
   logic [MOD_W-1:0]    inv_val;
   logic [MOD_W-1:0]    ifac_val;
   logic                wr_en;
   logic                div_start;
   logic [PROD_W-1:0]   div_dividend;
   logic [MOD_W-1:0]    div_divisor;
   div_result_type      div;
   logic                rsp_free;
   logic                rsp_load;
   logic signed [ARG_W-1:0] n_s;
   logic signed [ARG_W-1:0] k_s;
   state_type           dispatch;

   assign n_s = $signed(n_ff);
   assign k_s = $signed(k_ff);

   // The response register frees up when it is empty or being taken now.
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = (state_ff == S_DONE) && rsp_free;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);

   // Entries 0 and 1 never live in the RAMs; they are fixed values.
   assign fac_val  = rd_low_ff ? MOD_W'(1) : fac_q;
   assign ifac_val = rd_low_ff ? MOD_W'(1) : ifac_q;
   assign inv_val  = rd_low_ff ? MOD_W'(rd_one_ff) : inv_q;

   always_comb begin
      case (state_ff)
         S_XRD:   rd_addr = ADDR_W'(filled_ff - 1'b1);
         S_XINVA: rd_addr = ADDR_W'(r_ff);
         S_QRDK:  rd_addr = ADDR_W'(k_ff);
         S_QRD2:  rd_addr = ADDR_W'(nk_ff);
         default: rd_addr = ADDR_W'(n_ff);
      endcase
   end

   // Where a request goes once the tables cover n.
   always_comb begin
      case (type_ff)
         REQ_COMB: dispatch = S_QRDK;
         REQ_PERM: dispatch = S_QRDN;
         default:  dispatch = S_DIRECT;
      endcase
   end

   assign wr_en        = (state_ff == S_XWR);
   assign div_start    = (state_ff == S_XDIV) || (state_ff == S_RED);
   assign div_dividend = (state_ff == S_XDIV) ? {{MOD_W{1'b0}}, modulus_ff} : prod_ff;
   assign div_divisor  = (state_ff == S_XDIV) ? MOD_W'(i_ff) : modulus_ff;

   bmf_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .result   (div)
   );

   bmf_ram #(.DEPTH(TABLE_SIZE), .ADDR_W(ADDR_W)) u_fac (
      .clock (clock), .wr_en (wr_en), .wr_addr (ADDR_W'(i_ff)),
      .wr_data (fac_new_ff), .rd_addr (rd_addr), .rd_data (fac_q)
   );

   bmf_ram #(.DEPTH(TABLE_SIZE), .ADDR_W(ADDR_W)) u_inv (
      .clock (clock), .wr_en (wr_en), .wr_addr (ADDR_W'(i_ff)),
      .wr_data (iv_ff), .rd_addr (rd_addr), .rd_data (inv_q)
   );

   bmf_ram #(.DEPTH(TABLE_SIZE), .ADDR_W(ADDR_W)) u_ifac (
      .clock (clock), .wr_en (wr_en), .wr_addr (ADDR_W'(i_ff)),
      .wr_data (div.rem), .rd_addr (rd_addr), .rd_data (ifac_q)
   );

   always_ff @(posedge clock) begin
      rd_low_ff <= (rd_addr < ADDR_W'(2));
      rd_one_ff <= (rd_addr == ADDR_W'(1));
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         modulus_ff   <= MODULUS_RESET;
         filled_ff    <= CNT_W'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         // A new response may replace one that is being taken this cycle.
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (csr_valid) begin
                  modulus_ff <= (csr_modulus < MOD_W'(2)) ? MOD_W'(2) : csr_modulus;
                  filled_ff  <= CNT_W'(2);
               end
               if (req_valid) begin
                  type_ff  <= req_type;
                  n_ff     <= req_n_value;
                  k_ff     <= req_k_value;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               result_ff <= '0;
               flag_ff   <= 1'b0;
               nk_ff     <= n_ff - k_ff;
               a_ff      <= MOD_W'(1);
               i_ff      <= filled_ff;
               if (type_ff > REQ_IFACT) begin
                  state_ff <= S_DONE;
               end else if ((type_ff <= REQ_PERM) && (k_s < 0 || n_s < k_s)) begin
                  state_ff <= S_DONE;
               end else if (n_s < 0) begin
                  state_ff <= S_DONE;
               end else if ({19'b0, n_ff} >= 32'(TABLE_SIZE) ||
                            {{(MOD_W-ARG_W){1'b0}}, n_ff} >= modulus_ff) begin
                  flag_ff  <= 1'b1;
                  state_ff <= S_DONE;
               end else if (CNT_W'(n_ff) >= filled_ff) begin
                  state_ff <= S_XRD;
               end else begin
                  state_ff <= dispatch;
               end
            end
            // Table extension, one new index per pass.
            S_XRD:    state_ff <= S_XLATCH;
            S_XLATCH: begin
               fac_prev_ff  <= fac_val;
               ifac_prev_ff <= ifac_val;
               state_ff     <= S_XDIV;
            end
            S_XDIV:   state_ff <= S_XDIVW;
            S_XDIVW: begin
               if (div.done) begin
                  q_ff     <= div.quot;
                  r_ff     <= div.rem;
                  state_ff <= S_XINVA;
               end
            end
            S_XINVA:  state_ff <= S_XINVM;
            S_XINVM: begin
               prod_ff  <= inv_val * q_ff;
               ret_ff   <= S_XIV;
               state_ff <= S_RED;
            end
            S_XIV: begin
               iv_ff    <= (div.rem == '0) ? '0 : modulus_ff - div.rem;
               prod_ff  <= MOD_W'(i_ff) * fac_prev_ff;
               ret_ff   <= S_XFAC;
               state_ff <= S_RED;
            end
            S_XFAC: begin
               fac_new_ff <= div.rem;
               prod_ff    <= ifac_prev_ff * iv_ff;
               ret_ff     <= S_XWR;
               state_ff   <= S_RED;
            end
            S_XWR: begin
               fac_prev_ff  <= fac_new_ff;
               ifac_prev_ff <= div.rem;
               filled_ff    <= i_ff + 1'b1;
               i_ff         <= i_ff + 1'b1;
               state_ff     <= (i_ff == CNT_W'(n_ff)) ? dispatch : S_XDIV;
            end
            // Combination and permutation products.
            S_QRDK:   state_ff <= S_QRDN;
            S_QRDN: begin
               if (type_ff == REQ_COMB) begin
                  a_ff <= ifac_val;
               end
               state_ff <= S_QMUL1;
            end
            S_QMUL1: begin
               prod_ff  <= fac_val * a_ff;
               ret_ff   <= S_QRD2;
               state_ff <= S_RED;
            end
            S_QRD2: begin
               acc_ff   <= div.rem;
               state_ff <= S_QMUL2;
            end
            S_QMUL2: begin
               prod_ff  <= acc_ff * ifac_val;
               ret_ff   <= S_QEND;
               state_ff <= S_RED;
            end
            S_QEND: begin
               result_ff <= div.rem;
               state_ff  <= S_DONE;
            end
            // Plain table lookups.
            S_DIRECT: state_ff <= S_DIRECTW;
            S_DIRECTW: begin
               case (type_ff)
                  REQ_FACT: result_ff <= fac_val;
                  REQ_INV:  result_ff <= inv_val;
                  default:  result_ff <= ifac_val;
               endcase
               state_ff <= S_DONE;
            end
            // Shared reduction: prod_ff mod modulus, then back to ret_ff.
            S_RED:    state_ff <= S_REDW;
            S_REDW: begin
               if (div.done) begin
                  state_ff <= ret_ff;
               end
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_value_ff <= result_ff;
                  rsp_flag_ff  <= flag_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_out_of_range = rsp_flag_ff;

   a_filled_bounds: assert property (@(posedge clock) disable iff (reset)
      filled_ff >= CNT_W'(2) && filled_ff <= CNT_W'(TABLE_SIZE))
      else $error("filled length out of bounds");

   a_result_below_mod: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_value < modulus_ff)
      else $error("response not reduced");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_result_value == '0)
      else $error("out-of-range response with nonzero value");

   a_ext_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_XDIV |-> i_ff == filled_ff)
      else $error("extension index does not follow filled length");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div.done |-> (state_ff == S_REDW || state_ff == S_XDIVW))
      else $error("divider finished outside a wait state");

endmodule
